[hdl/rsbp_pkg.sv]
// ----------------------------------------------------------------------------
// rsbp_pkg
// Shared constants and types of the range scaled bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsbp_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int BYTE_W          = 8;
  localparam int FIELD_W         = 32;
  localparam int NBITS_W         = 6;   // field width 0..32
  localparam int GRP_BYTES       = 4;   // most bytes one reading can finish
  localparam int GRP_CNT_W       = 3;   // 0..GRP_BYTES
  localparam int GRP_IDX_W       = 2;
  localparam int ACC_W           = FIELD_W + BYTE_W;
  localparam int USER_W          = 2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam int USER_VALID_BIT = 0;
  localparam int USER_OVF_BIT   = 1;

  typedef struct packed {
    logic                 cmd;
    logic [FIELD_W-1:0]   val;    // clamped offset, zero above nbits
    logic [NBITS_W-1:0]   nbits;
  } item_t;

  typedef struct packed {
    logic [GRP_BYTES-1:0][BYTE_W-1:0] data;
    logic [GRP_CNT_W-1:0]             cnt;
    logic                             bvalid;
    logic                             last;
    logic                             ovf;
  } grp_t;

endpackage

`default_nettype wire

[hdl/rsbp_front.sv]
// ----------------------------------------------------------------------------
// rsbp_front
// Three-stage front end: input register, range subtract, width and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbp_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_cmd,
  input  wire signed [rsbp_pkg::FIELD_W-1:0] in_reading,
  input  wire signed [rsbp_pkg::FIELD_W-1:0] in_lower,
  input  wire signed [rsbp_pkg::FIELD_W-1:0] in_upper,
  output logic                              out_valid,
  input  wire                               out_ready,
  output rsbp_pkg::item_t                   out_item
);

  localparam int W  = rsbp_pkg::FIELD_W;
  localparam int NW = rsbp_pkg::NBITS_W;

  // stage 1: raw fields
  logic                s1_v_r;
  logic                s1_cmd_r;
  logic signed [W-1:0] s1_rd_r, s1_lo_r, s1_hi_r;
  // stage 2: spread - 1 and offset
  logic                s2_v_r;
  logic                s2_cmd_r;
  logic signed [W:0]   s2_sm1_r;
  logic signed [W:0]   s2_off_r;
  // stage 3: result item
  logic                s3_v_r;
  rsbp_pkg::item_t     s3_r;

  logic                s1_rdy, s2_rdy, s3_rdy;
  logic signed [W:0]   sm1_nxt, off_nxt;
  logic                empty;
  logic [NW-1:0]       nbits;
  logic [W-1:0]        mask;
  logic                over;
  logic [W-1:0]        val;

  assign s3_rdy   = !s3_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // hi - lo - 1 == hi + ~lo
  assign sm1_nxt = {s1_hi_r[W-1], s1_hi_r} + {~s1_lo_r[W-1], ~s1_lo_r};
  assign off_nxt = {s1_rd_r[W-1], s1_rd_r} - {s1_lo_r[W-1], s1_lo_r};

  assign empty = s2_sm1_r[W] || (s2_sm1_r == '0);

  always_comb begin
    nbits = '0;
    for (int i = 0; i < W; i++) begin
      if (s2_sm1_r[i]) begin
        nbits = NW'(i + 1);
      end
    end
    if (empty) begin
      nbits = '0;
    end
    for (int i = 0; i < W; i++) begin
      mask[i] = (NW'(i) < nbits);
    end
    over = |(s2_off_r[W-1:0] & ~mask);
    if (s2_off_r[W]) begin
      val = '0;
    end else if (over) begin
      val = mask;
    end else begin
      val = s2_off_r[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_cmd_r <= in_cmd;
      s1_rd_r  <= in_reading;
      s1_lo_r  <= in_lower;
      s1_hi_r  <= in_upper;
    end
    if (s2_rdy && s1_v_r) begin
      s2_cmd_r <= s1_cmd_r;
      s2_sm1_r <= sm1_nxt;
      s2_off_r <= off_nxt;
    end
    if (s3_rdy && s2_v_r) begin
      s3_r.cmd   <= s2_cmd_r;
      s3_r.val   <= val;
      s3_r.nbits <= nbits;
    end
  end

  assign out_valid = s3_v_r;
  assign out_item  = s3_r;

endmodule

`default_nettype wire

[hdl/rsbp_pack.sv]
// ----------------------------------------------------------------------------
// rsbp_pack
// Frame state and bit merge; turns one item into a group of 0..4 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbp_pack #(
  parameter int FRAME_BYTES = rsbp_pkg::FRAME_BYTES_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  rsbp_pkg::item_t  in_item,
  output logic             grp_valid,
  input  wire              grp_ready,
  output rsbp_pkg::grp_t   grp
);

  localparam int BW  = $clog2(FRAME_BYTES + 1);
  localparam int CW  = (BW > rsbp_pkg::GRP_CNT_W) ? BW : rsbp_pkg::GRP_CNT_W;
  localparam int AW  = rsbp_pkg::ACC_W;
  localparam int B   = rsbp_pkg::BYTE_W;
  localparam int NW  = rsbp_pkg::NBITS_W;
  localparam int GCW = rsbp_pkg::GRP_CNT_W;

  logic [B-1:0]  partial_r, partial_nxt;
  logic [2:0]    fill_r, fill_nxt;
  logic [BW-1:0] sent_r, sent_nxt;
  logic          ovf_r, ovf_nxt;

  logic [AW-1:0]  acc;
  logic [NW-1:0]  total;
  logic [GCW-1:0] nbytes, keep;
  logic [CW-1:0]  room;
  logic           short;
  logic           emit, consume;

  always_comb begin
    acc    = AW'(partial_r) | (AW'(in_item.val) << fill_r);
    total  = NW'(fill_r) + in_item.nbits;
    nbytes = total[NW-1:3];
    room   = CW'(FRAME_BYTES) - CW'(sent_r);
    short  = CW'(nbytes) > room;
    keep   = short ? GCW'(room) : nbytes;

    partial_nxt = partial_r;
    fill_nxt    = fill_r;
    sent_nxt    = sent_r;
    ovf_nxt     = ovf_r;
    grp         = '0;

    if (in_item.cmd == rsbp_pkg::CMD_FLUSH) begin
      grp.cnt    = GCW'(1);
      grp.last   = 1'b1;
      grp.bvalid = (fill_r != '0) && (room != '0);
      grp.data[0] = grp.bvalid ? partial_r : '0;
      grp.ovf    = ovf_r || ((fill_r != '0) && (room == '0));
      partial_nxt = '0;
      fill_nxt    = '0;
      sent_nxt    = '0;
      ovf_nxt     = 1'b0;
    end else begin
      for (int j = 0; j < rsbp_pkg::GRP_BYTES; j++) begin
        grp.data[j] = acc[j*B +: B];
      end
      grp.cnt     = keep;
      grp.bvalid  = 1'b1;
      grp.last    = 1'b0;
      grp.ovf     = ovf_r;
      partial_nxt = acc[{nbytes, 3'b000} +: B];
      fill_nxt    = total[2:0];
      sent_nxt    = BW'(CW'(sent_r) + CW'(keep));
      ovf_nxt     = ovf_r || short;
    end

    emit      = grp.cnt != '0;
    in_ready  = !emit || grp_ready;
    grp_valid = in_valid && emit;
    consume   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= '0;
      sent_r    <= '0;
      ovf_r     <= 1'b0;
    end else if (consume) begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
      sent_r    <= sent_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(sent_r) <= CW'(FRAME_BYTES))
    else $error("byte count past frame size");
`endif

endmodule

`default_nettype wire

[hdl/rsbp_drain.sv]
// ----------------------------------------------------------------------------
// rsbp_drain
// Byte group register and output register; sends one byte per cycle while out_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbp_drain (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                grp_valid,
  output logic                               grp_ready,
  input  rsbp_pkg::grp_t                     grp,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [rsbp_pkg::BYTE_W-1:0]        out_tdata,
  output logic [rsbp_pkg::USER_W-1:0]        out_tuser,
  output logic                               out_tlast
);

  localparam int GCW = rsbp_pkg::GRP_CNT_W;
  localparam int GIW = rsbp_pkg::GRP_IDX_W;

  rsbp_pkg::grp_t                  grp_r;
  logic                            grp_v_r;
  logic [GIW-1:0]                  idx_r;
  logic                            out_v_r;
  logic [rsbp_pkg::BYTE_W-1:0]     out_data_r;
  logic [rsbp_pkg::USER_W-1:0]     out_user_r;
  logic                            out_last_r;

  logic move, last_idx;
  logic [rsbp_pkg::USER_W-1:0] user;

  assign move      = grp_v_r && (!out_v_r || out_tready);
  assign last_idx  = (GCW'(idx_r) + GCW'(1)) == grp_r.cnt;
  assign grp_ready = !grp_v_r || (move && last_idx);

  always_comb begin
    user = '0;
    user[rsbp_pkg::USER_VALID_BIT] = grp_r.bvalid;
    user[rsbp_pkg::USER_OVF_BIT]   = grp_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (grp_valid && grp_ready) begin
        grp_v_r <= 1'b1;
        idx_r   <= '0;
      end else if (move && last_idx) begin
        grp_v_r <= 1'b0;
      end else if (move) begin
        idx_r <= idx_r + GIW'(1);
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      grp_r <= grp;
    end
    if (move) begin
      out_data_r <= grp_r.data[idx_r];
      out_user_r <= user;
      out_last_r <= grp_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    grp_v_r |-> (grp_r.cnt != '0) && (GCW'(idx_r) < grp_r.cnt))
    else $error("byte group index out of range");
`endif
`ifndef SYNTHESIS
  a_hollow_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_user_r[rsbp_pkg::USER_VALID_BIT]) |-> out_last_r)
    else $error("empty byte outside frame end");
`endif
`ifndef SYNTHESIS
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_v_r && grp_r.last) |-> (grp_r.cnt == GCW'(1)))
    else $error("frame end group holds more than one byte");
`endif

endmodule

`default_nettype wire

[hdl/range_scaled_bit_packer_unit.sv]
// ----------------------------------------------------------------------------
// range_scaled_bit_packer_unit
// Packs range-limited readings LSB first into a byte frame.
// ----------------------------------------------------------------------------
// An item can be accepted every cycle while nothing stalls. Each append
// item yields 0 to 4 bytes and a flush yields one word with tlast; bytes
// leave one per cycle through the output register while out_tready is
// high, and an item with more than one byte holds back the items behind
// it. Input passes through three front stages, the group register and the
// output register. Bytes past FRAME_BYTES in a frame are dropped and flagged.
`default_nettype none

module range_scaled_bit_packer_unit #(
  parameter int FRAME_BYTES = rsbp_pkg::FRAME_BYTES_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [3*rsbp_pkg::FIELD_W-1:0]    in_tdata,   // reading, lower_limit, upper_limit
  input  wire                              in_tuser,   // cmd
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [rsbp_pkg::BYTE_W-1:0]      out_tdata,  // out_byte
  output logic [rsbp_pkg::USER_W-1:0]      out_tuser,  // byte_valid, overflowed
  output logic                             out_tlast   // frame_end
);

  localparam int W = rsbp_pkg::FIELD_W;

  logic            f_valid, f_ready;
  rsbp_pkg::item_t f_item;
  logic            g_valid, g_ready;
  rsbp_pkg::grp_t  g;

  rsbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_reading (in_tdata[W-1:0]),
    .in_lower   (in_tdata[2*W-1:W]),
    .in_upper   (in_tdata[3*W-1:2*W]),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_item   (f_item)
  );

  rsbp_pack #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .grp_valid (g_valid),
    .grp_ready (g_ready),
    .grp       (g)
  );

  rsbp_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (g_valid),
    .grp_ready  (g_ready),
    .grp        (g),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_scaled_bit_packer_unit.
// ----------------------------------------------------------------------------
// Readings with random limits are streamed in. The bench works out each
// field width and the clamped offset, packs the bits LSB first into frame
// bytes on its own, and checks every output word in order. A short
// directed run covers empty and inverted ranges, one-bit and full 32-bit
// fields, out-of-range readings and flushes with and without a partial
// byte. Random frames follow; a third of them are long enough to overrun
// the frame buffer. Both sides idle and stall at random; the directed run and
// one random phase run with no idling at all.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      FRAME_LEN  = rsbp_pkg::FRAME_BYTES_DEF;
  localparam int      CYCLE_CAP  = 400000;
  localparam longint  S32_MIN    = -64'sd2147483648;
  localparam longint  S32_MAX    = 64'sd2147483647;

  typedef struct {
    logic        cmd;
    logic [31:0] rd;
    logic [31:0] lo;
    logic [31:0] hi;
  } reading_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       last;
    logic       ovf;
  } frame_word_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [3*rsbp_pkg::FIELD_W-1:0]    in_tdata   = '0;
  logic                              in_tuser   = rsbp_pkg::CMD_APPEND;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [rsbp_pkg::BYTE_W-1:0]       out_tdata;
  logic [rsbp_pkg::USER_W-1:0]       out_tuser;
  logic                              out_tlast;

  reading_item_t pending_items[$];
  frame_word_t   expected_words[$];

  // packing state of the bench
  logic [7:0] acc_byte;
  int         acc_bits;
  int         bytes_out;
  bit         ovf_seen;

  bit         in_fire = 1'b0;
  bit         in_idle_en;
  bit         out_idle_en;
  int         gap_left;
  int         stall_left;
  int         cycles;
  int         errors;
  int         items_sent;
  int         words_checked;
  int         frames_done;
  int         frames_ovf;
  reading_item_t drv_item;

  range_scaled_bit_packer_unit #(.FRAME_BYTES(FRAME_LEN)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint rnd_between(longint a, longint b);
    bit [63:0] r;
    r = {$urandom, $urandom};
    return a + longint'(r % (b - a + 1));
  endfunction

  task automatic emit_byte(logic [7:0] b, bit last, output bit wrote);
    if (bytes_out < FRAME_LEN) begin
      bytes_out++;
      expected_words.push_back('{data: b, bvalid: 1'b1, last: last, ovf: ovf_seen});
      wrote = 1'b1;
    end else begin
      ovf_seen = 1'b1;
      wrote = 1'b0;
    end
  endtask

  task automatic clear_frame();
    acc_byte  = '0;
    acc_bits  = 0;
    bytes_out = 0;
    ovf_seen  = 1'b0;
  endtask

  task automatic pack_reading(logic cmd, int rd, int lo, int hi);
    longint spread;
    longint off;
    longint top;
    longint val;
    int     n;
    bit     wrote;
    if (cmd == rsbp_pkg::CMD_FLUSH) begin
      wrote = 1'b0;
      if (acc_bits != 0) emit_byte(acc_byte, 1'b1, wrote);
      if (!wrote)
        expected_words.push_back('{data: 8'h00, bvalid: 1'b0, last: 1'b1, ovf: ovf_seen});
      clear_frame();
    end else begin
      spread = longint'(hi) - longint'(lo);
      if (spread <= 1) return;
      n = 0;
      while (n < 32 && (longint'(1) << n) < spread) n++;
      top = (longint'(1) << n) - 1;
      off = longint'(rd) - longint'(lo);
      if (off < 0)        val = 0;
      else if (off > top) val = top;
      else                val = off;
      for (int i = 0; i < n; i++) begin
        acc_byte[acc_bits] = val[i];
        acc_bits++;
        if (acc_bits == 8) begin
          emit_byte(acc_byte, 1'b0, wrote);
          acc_byte = '0;
          acc_bits = 0;
        end
      end
    end
  endtask

  task automatic queue_item(logic cmd, longint rd, longint lo, longint hi);
    pending_items.push_back('{cmd: cmd, rd: rd[31:0], lo: lo[31:0], hi: hi[31:0]});
  endtask

  task automatic queue_flush();
    queue_item(rsbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);
  endtask

  // field width drawn from nmin..nmax, limits and reading built around it
  task automatic queue_append(int nmin, int nmax);
    longint span;
    longint lo;
    longint rd;
    int     n;
    int     r;
    n    = $urandom_range(nmin, nmax);
    span = rnd_between((n == 1) ? 2 : (longint'(1) << (n - 1)) + 1,
                       (n == 32) ? 64'd4294967295 : (longint'(1) << n));
    lo   = longint'(int'($urandom));
    if (lo + span > S32_MAX) lo = S32_MAX - span;
    r = $urandom_range(0, 99);
    if (r < 10)      rd = rnd_between(S32_MIN, lo);
    else if (r < 20) rd = rnd_between(lo + span, S32_MAX);
    else if (r < 30) rd = longint'(int'($urandom));
    else             rd = rnd_between(lo, lo + span);
    queue_item(rsbp_pkg::CMD_APPEND, rd, lo, lo + span);
  endtask

  task automatic queue_noise();
    longint lo;
    lo = longint'(int'($urandom));
    if ($urandom_range(0, 1))
      queue_item(rsbp_pkg::CMD_APPEND, $urandom, lo, $urandom);
    else
      queue_item(rsbp_pkg::CMD_APPEND, $urandom, lo,
                 lo - $urandom_range(0, 1) + $urandom_range(0, 2));
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_item.cmd;
        in_tdata  <= {drv_item.hi, drv_item.lo, drv_item.rd};
        gap_left  <= pick_gap(in_idle_en);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap(out_idle_en);
    end
  end

  // prediction on input words, checking on output words
  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        items_sent++;
        pack_reading(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
      end
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, bvalid: out_tuser[rsbp_pkg::USER_VALID_BIT],
                last: out_tlast, ovf: out_tuser[rsbp_pkg::USER_OVF_BIT]};
        words_checked++;
        if (out_tlast) begin
          frames_done++;
          if (got.ovf) frames_ovf++;
        end
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word data=%h valid=%b last=%b ovf=%b",
                   $time, got.data, got.bvalid, got.last, got.ovf);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected data=%h valid=%b last=%b ovf=%b,",
                     $time, want.data, want.bvalid, want.last, want.ovf);
            $display("    got data=%h valid=%b last=%b ovf=%b",
                     got.data, got.bvalid, got.last, got.ovf);
          end
        end
      end
    end
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n_frame;
    clear_frame();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    queue_flush();
    queue_item(rsbp_pkg::CMD_APPEND, 5, 5, 5);
    queue_item(rsbp_pkg::CMD_APPEND, 0, 10, 3);
    queue_item(rsbp_pkg::CMD_APPEND, 0, S32_MAX, S32_MIN);
    queue_item(rsbp_pkg::CMD_APPEND, 8, 7, 8);
    queue_item(rsbp_pkg::CMD_APPEND, 1, 0, 2);
    queue_item(rsbp_pkg::CMD_APPEND, -100, -4, -1);
    queue_item(rsbp_pkg::CMD_APPEND, 100, 0, 4);
    queue_flush();
    queue_item(rsbp_pkg::CMD_APPEND, S32_MAX, S32_MIN, S32_MAX);
    queue_item(rsbp_pkg::CMD_APPEND, S32_MIN, S32_MIN, S32_MAX);
    queue_item(rsbp_pkg::CMD_APPEND, 64'sh5A3C96F0, S32_MIN, S32_MAX);
    queue_item(rsbp_pkg::CMD_APPEND, 3, 0, 9);
    queue_flush();
    queue_item(rsbp_pkg::CMD_APPEND, 0, S32_MIN, S32_MAX);
    queue_flush();
    drain();

    // random frames in phases, idling on some
    for (int ph = 0; ph < 5; ph++) begin
      in_idle_en  = (ph != 1);
      out_idle_en = (ph != 1) && (ph != 3);
      n_frame = 0;
      while (n_frame < 40) begin
        if ($urandom_range(0, 2) == 0) begin
          for (int k = $urandom_range(20, 26); k > 0; k--) queue_append(26, 32);
          n_frame += 24;
        end else begin
          for (int k = $urandom_range(0, 8); k > 0; k--) begin
            if ($urandom_range(0, 11) == 0) queue_noise();
            else queue_append(1, 32);
            n_frame++;
          end
        end
        queue_flush();
        n_frame++;
      end
      if (ph % 2 == 0) drain();
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Sent %0d items, checked %0d output words over %0d frames", items_sent,
             words_checked, frames_done);
    $display("%0d frames overran the %0d-byte buffer", frames_ovf, FRAME_LEN);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
